### rtl/mdio_mgmt_pkg.sv
// Shared types, frame constants and the frame builder for the MDIO management master.
// No dependencies; every other RTL file imports this package.
package mdio_mgmt_pkg;

   // Frame layout, bit positions counted from the first bit sent
   localparam int BIT_POS_W = 6;
   localparam logic [BIT_POS_W-1:0] ADDR_END_BIT   = 6'd46;
   localparam logic [BIT_POS_W-1:0] DATA_FIRST_BIT = 6'd47;
   localparam logic [BIT_POS_W-1:0] DATA_LAST_BIT  = 6'd62;
   localparam logic [BIT_POS_W-1:0] LAST_BIT       = 6'd63;

   // Start/opcode and write turnaround patterns
   localparam logic [3:0] ST_OP_READ  = 4'b0110;
   localparam logic [3:0] ST_OP_WRITE = 4'b0101;
   localparam logic [1:0] TA_WRITE    = 2'b10;

   // MDC divider
   localparam int DIV_W = 16;
   localparam logic [DIV_W-1:0] DIV_RESET = 16'd16;

   // Command queue between front and engine
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_CNT_W = 3;

   typedef struct packed {
      logic        start_req;
      logic        mode;
      logic [4:0]  phy_address;
      logic [4:0]  register_address;
      logic [15:0] write_data;
      logic        mdio_in;
   } mdio_req_type;

   typedef struct packed {
      logic        mdc;
      logic        mdio_out;
      logic        mdio_drive;
      logic        busy_res;
      logic        done_res;
      logic [15:0] read_data;
   } mdio_rsp_type;

   // Classified tick handed from front to engine. The upper 32 frame bits
   // are always preamble ones, so only the lower word is carried.
   typedef struct packed {
      logic        start_req;
      logic        is_write;
      logic [31:0] frame_low;
      logic        mdio_in;
   } mdio_cmd_type;

   // Lower frame word: start/opcode, addresses, then turnaround and data on a write
   function automatic logic [31:0] build_frame_low(input logic       wr,
                                                   input logic [4:0] phy,
                                                   input logic [4:0] reg_addr,
                                                   input logic [15:0] data);
      logic [31:0] f;
      f = {(wr ? ST_OP_WRITE : ST_OP_READ), phy, reg_addr, 18'd0};
      if (wr) begin
         f[17:0] = {TA_WRITE, data};
      end
      return f;
   endfunction

endpackage

### rtl/mdio_mgmt_front.sv
// Front stage: takes request transfers, builds the frame word and pushes the
// classified tick into the command queue. Depends on mdio_mgmt_pkg.
module mdio_mgmt_front
   import mdio_mgmt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  mdio_req_type req_data,
   input  logic         q_full,
   output logic         q_push,
   output mdio_cmd_type q_push_data
);

   logic         front_v_ff, front_v_in;
   mdio_cmd_type front_ff, front_in;
   logic         take;

   // Stage is free when empty or when its content moves on this cycle
   assign q_push    = front_v_ff && !q_full;
   assign req_ready = !front_v_ff || !q_full;
   assign take      = req_valid && req_ready;
   assign q_push_data = front_ff;

   always_comb begin
      front_v_in = take ? 1'b1 : (q_push ? 1'b0 : front_v_ff);
      front_in.start_req = req_data.start_req;
      front_in.is_write  = req_data.mode;
      front_in.frame_low = build_frame_low(req_data.mode, req_data.phy_address,
                                           req_data.register_address,
                                           req_data.write_data);
      front_in.mdio_in   = req_data.mdio_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_v_ff <= 1'b0;
      end else begin
         front_v_ff <= front_v_in;
      end
   end

   // Payload, no reset
   always_ff @(posedge clock) begin
      if (take) begin
         front_ff <= front_in;
      end
   end

endmodule

### rtl/mdio_mgmt_queue.sv
// Small command queue between the front stage and the serial engine.
// Depends on mdio_mgmt_pkg.
module mdio_mgmt_queue
   import mdio_mgmt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  mdio_cmd_type push_data,
   output logic         full,
   input  logic         pop,
   output logic         not_empty,
   output mdio_cmd_type head
);

   mdio_cmd_type           mem [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = mem[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/mdio_mgmt_engine.sv
// Serial engine: runs one MDC tick per queued command, holds the divider
// register and the response output register. Depends on mdio_mgmt_pkg.
module mdio_mgmt_engine
   import mdio_mgmt_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   input  logic [DIV_W-1:0] csr_data,
   input  logic             q_not_empty,
   input  mdio_cmd_type     q_head,
   output logic             q_pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output mdio_rsp_type     rsp_data
);

   // Divider, stored as the effective limit (zero acts as one)
   logic [DIV_W-1:0] limit_ff, limit_in;

   // Frame state
   logic                 active_ff, active_in;
   logic                 is_write_ff, is_write_in;
   logic [BIT_POS_W-1:0] bit_pos_ff, bit_pos_in;
   logic                 high_half_ff, high_half_in;
   logic [DIV_W-1:0]     tick_ff, tick_in;
   logic [31:0]          frame_ff, frame_in;
   logic [15:0]          shift_ff, shift_in;

   // Output register
   logic         rsp_v_ff, rsp_v_in;
   mdio_rsp_type rsp_ff, rsp_in;

   // Current-tick view after a possible start
   logic                 fire, start, cur_active, cur_wr, cur_hh, half_end;
   logic [BIT_POS_W-1:0] cur_bp;
   logic [DIV_W-1:0]     cur_tc, tc_inc;
   logic [31:0]          cur_frame;
   logic                 drive, dout, last_bit, sample;

   assign fire  = q_not_empty && (!rsp_v_ff || rsp_ready);
   assign q_pop = fire;

   always_comb begin
      limit_in = limit_ff;
      if (csr_valid) begin
         limit_in = (csr_data == '0) ? DIV_W'(1) : csr_data;
      end
   end

   // One tick of the frame engine
   always_comb begin
      start      = !active_ff && q_head.start_req;
      cur_active = active_ff || q_head.start_req;
      cur_wr     = start ? q_head.is_write  : is_write_ff;
      cur_frame  = start ? q_head.frame_low : frame_ff;
      cur_bp     = start ? '0   : bit_pos_ff;
      cur_hh     = start ? 1'b0 : high_half_ff;
      cur_tc     = start ? '0   : tick_ff;

      drive    = cur_active && (cur_wr || (cur_bp < ADDR_END_BIT));
      dout     = drive && (cur_bp[5] ? cur_frame[~cur_bp[4:0]] : 1'b1);
      tc_inc   = cur_tc + 1'b1;
      half_end = cur_active && (tc_inc >= limit_ff);
      last_bit = half_end && cur_hh && (cur_bp == LAST_BIT);
      sample   = half_end && cur_hh && !cur_wr &&
                 (cur_bp >= DATA_FIRST_BIT) && (cur_bp <= DATA_LAST_BIT);

      active_in    = cur_active && !last_bit;
      is_write_in  = cur_wr;
      frame_in     = cur_frame;
      bit_pos_in   = cur_bp;
      high_half_in = cur_hh;
      tick_in      = cur_active ? tc_inc : cur_tc;
      shift_in     = sample ? {shift_ff[14:0], q_head.mdio_in} : shift_ff;
      if (half_end) begin
         tick_in      = '0;
         high_half_in = !cur_hh;
         if (cur_hh) begin
            bit_pos_in = cur_bp + 1'b1;
         end
      end

      rsp_in.mdc        = cur_active && cur_hh;
      rsp_in.mdio_out   = dout;
      rsp_in.mdio_drive = drive;
      rsp_in.busy_res   = cur_active;
      rsp_in.done_res   = last_bit;
      rsp_in.read_data  = shift_in;

      rsp_v_in = fire || (rsp_v_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= DIV_RESET;
         active_ff    <= 1'b0;
         is_write_ff  <= 1'b0;
         bit_pos_ff   <= '0;
         high_half_ff <= 1'b0;
         tick_ff      <= '0;
         frame_ff     <= '0;
         shift_ff     <= '0;
         rsp_v_ff     <= 1'b0;
      end else begin
         limit_ff <= limit_in;
         rsp_v_ff <= rsp_v_in;
         if (fire) begin
            active_ff    <= active_in;
            is_write_ff  <= is_write_in;
            bit_pos_ff   <= bit_pos_in;
            high_half_ff <= high_half_in;
            tick_ff      <= tick_in;
            frame_ff     <= frame_in;
            shift_ff     <= shift_in;
         end
      end
   end

   // Response payload, no reset
   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_v_ff;
   assign rsp_data  = rsp_ff;

endmodule

### rtl/mdio_management_master_core.sv
// MDIO clause 22 management master; one request transfer is one MDC engine tick.
// A request transfer passes through the front register, the queue and the output register before its response.
// Throughput: one transfer per cycle while the response side does not stall, set by the single-tick engine update.
// Reset (synchronous, active high): idle, divider 16, read data 0, queue and stages empty.
// Divider writes are always accepted and are registered into the divider limit.
// Depends on mdio_mgmt_pkg, mdio_mgmt_front, mdio_mgmt_queue, mdio_mgmt_engine.
module mdio_management_master_core
   import mdio_mgmt_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  mdio_req_type     req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output mdio_rsp_type     rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [DIV_W-1:0] csr_data
);

   logic         q_full, q_push, q_pop, q_not_empty;
   mdio_cmd_type q_push_data, q_head;

   assign csr_ready = 1'b1;

   mdio_mgmt_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_push_data (q_push_data)
   );

   mdio_mgmt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   mdio_mgmt_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_data    (csr_data),
      .q_not_empty (q_not_empty),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule

### rtl/mdio_mgmt_checker.sv
// Port-level checker for mdio_management_master_core, attached by bind.
// Depends on mdio_mgmt_pkg.
module mdio_mgmt_checker
   import mdio_mgmt_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input mdio_rsp_type rsp_data
);

   // No response right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // Frame end only inside a frame
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.done_res |-> rsp_data.busy_res)
      else $error("done outside a frame");

   // Released line carries no level
   a_release_low: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.mdio_drive |-> !rsp_data.mdio_out)
      else $error("mdio_out high while released");

   // Idle lines are quiet
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.busy_res |-> !rsp_data.mdc && !rsp_data.mdio_drive)
      else $error("MDC or drive active while idle");

endmodule

bind mdio_management_master_core mdio_mgmt_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

### tb/testbench.sv
// Self-checking bench for mdio_management_master_core: one request transfer per engine tick.
// Predicts MDC/MDIO line levels, busy/done and read data tick by tick; needs mdio_mgmt_pkg.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import mdio_mgmt_pkg::*;

   localparam int CLOCK_PERIOD  = 20;
   localparam int RESET_CYCLES  = 9;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 12;

   // Tick-accurate copy of the serial engine plus the queue of line levels still due
   class mdio_tick_checker;
      bit [DIV_W-1:0]     half_ticks;
      bit                 active;
      bit                 is_write;
      bit [BIT_POS_W-1:0] bit_pos;
      bit                 high_half;
      bit [DIV_W-1:0]     tick_cnt;
      bit [63:0]          frame;
      bit [15:0]          read_shift;
      mdio_rsp_type       line_levels_due[$];
      int                 errors;

      function new();
         half_ticks = DIV_RESET;
         errors     = 0;
      endfunction

      function void set_divider(bit [DIV_W-1:0] value);
         half_ticks = value;
      endfunction

      function int pending();
         return line_levels_due.size();
      endfunction

      // Advance the engine by one tick for an accepted request
      function void note_tick(mdio_req_type req);
         bit [DIV_W-1:0] limit;
         mdio_rsp_type   want;
         limit = (half_ticks == '0) ? 16'd1 : half_ticks;
         // a start while idle latches the frame; the same tick is bit 0, low half
         if (!active && req.start_req) begin
            is_write  = req.mode;
            frame     = {32'hFFFF_FFFF, (is_write ? ST_OP_WRITE : ST_OP_READ),
                         req.phy_address, req.register_address,
                         (is_write ? {TA_WRITE, req.write_data} : 18'd0)};
            active    = 1'b1;
            bit_pos   = '0;
            high_half = 1'b0;
            tick_cnt  = '0;
         end
         want = '0;
         if (active) begin
            want.busy_res   = 1'b1;
            want.mdc        = high_half;
            want.mdio_drive = is_write || (bit_pos < ADDR_END_BIT);
            if (want.mdio_drive) begin
               want.mdio_out = frame[63 - bit_pos];
            end
            tick_cnt = tick_cnt + 1'b1;
            if (tick_cnt >= limit) begin
               tick_cnt = '0;
               if (!high_half) begin
                  high_half = 1'b1;
               end else begin
                  // sample data bits at the end of the high half on reads
                  if (!is_write && bit_pos >= DATA_FIRST_BIT && bit_pos <= DATA_LAST_BIT) begin
                     read_shift = {read_shift[14:0], req.mdio_in};
                  end
                  high_half = 1'b0;
                  if (bit_pos == LAST_BIT) begin
                     bit_pos        = '0;
                     active         = 1'b0;
                     want.done_res  = 1'b1;
                  end else begin
                     bit_pos = bit_pos + 1'b1;
                  end
               end
            end
         end
         want.read_data = read_shift;
         line_levels_due.push_back(want);
      endfunction

      function void field_check(string field, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
            errors++;
         end
      endfunction

      // Compare one response transfer against the oldest prediction
      function void check_line(mdio_rsp_type got);
         mdio_rsp_type want;
         if (line_levels_due.size() == 0) begin
            $display("%0t: unexpected response, expected none, got %h", $time, got);
            errors++;
            return;
         end
         want = line_levels_due.pop_front();
         field_check("mdc", 16'(want.mdc), 16'(got.mdc));
         field_check("mdio_out", 16'(want.mdio_out), 16'(got.mdio_out));
         field_check("mdio_drive", 16'(want.mdio_drive), 16'(got.mdio_drive));
         field_check("busy_res", 16'(want.busy_res), 16'(got.busy_res));
         field_check("done_res", 16'(want.done_res), 16'(got.done_res));
         field_check("read_data", want.read_data, got.read_data);
      endfunction
   endclass

   logic             clock;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   mdio_req_type     req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   mdio_rsp_type     rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [DIV_W-1:0] csr_data  = '0;

   mdio_tick_checker line_check = new();
   int               send_steady = 0;
   int               recv_steady = 0;

   mdio_management_master_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Idle length: mostly none or short, a few long, occasional stretches with none
   function automatic int pick_gap(inout int steady);
      int r;
      if (steady > 0) begin
         steady--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         steady = $urandom_range(40, 160);
         return 0;
      end
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   function automatic mdio_req_type random_request(int start_pct);
      mdio_req_type r;
      r.start_req        = ($urandom_range(0, 99) < start_pct);
      r.mode             = 1'($urandom_range(0, 1));
      r.phy_address      = 5'($urandom_range(0, 31));
      r.register_address = 5'($urandom_range(0, 31));
      r.write_data       = 16'($urandom_range(0, 65535));
      r.mdio_in          = 1'($urandom_range(0, 1));
      return r;
   endfunction

   // One request transfer, after a random gap
   task automatic send_tick(input mdio_req_type item);
      int gap;
      gap = pick_gap(send_steady);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      line_check.note_tick(item);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (line_check.pending() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Divider write, only with nothing in flight
   task automatic write_divider(input logic [DIV_W-1:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      line_check.set_divider(value);
   endtask

   task automatic run_random(input int count, input int start_pct, input bit hold_off);
      int pct;
      pct = start_pct;
      for (int i = 0; i < count; i++) begin
         // now and then a stretch with almost no start requests
         if (i % 32 == 0) begin
            pct = ($urandom_range(0, 7) == 0) ? 2 : start_pct;
         end
         if (hold_off && i == count / 2) begin
            req_valid <= 1'b0;
            while (line_check.pending() > 0) @(posedge clock);
         end
         send_tick(random_request(pct));
      end
   endtask

   // Response side: random stalls, every transfer checked
   initial begin
      int stall;
      stall = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            line_check.check_line(rsp_data);
            stall = pick_gap(recv_steady);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            stall--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog
   initial begin
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("testbench: FAIL");
      $finish;
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed ticks at the reset divider: idle, a write start, starts while busy
      send_tick(mdio_req_type'{1'b0, 1'b1, 5'd31, 5'd31, 16'hFFFF, 1'b1});
      send_tick(mdio_req_type'{1'b0, 1'b0, 5'd0, 5'd0, 16'h0000, 1'b0});
      send_tick(mdio_req_type'{1'b1, 1'b1, 5'd31, 5'd31, 16'hFFFF, 1'b1});
      send_tick(mdio_req_type'{1'b1, 1'b0, 5'd0, 5'd0, 16'h0000, 1'b0});
      send_tick(mdio_req_type'{1'b1, 1'b0, 5'd31, 5'd0, 16'hFFFF, 1'b0});
      send_tick(mdio_req_type'{1'b1, 1'b1, 5'd0, 5'd31, 16'h0000, 1'b1});
      send_tick(mdio_req_type'{1'b1, 1'b0, 5'h15, 5'h0A, 16'hA5A5, 1'b1});
      send_tick(mdio_req_type'{1'b1, 1'b1, 5'h0A, 5'h15, 16'h5A5A, 1'b0});
      send_tick(mdio_req_type'{1'b0, 1'b0, 5'd31, 5'd31, 16'hFFFF, 1'b1});
      for (int i = 0; i < 11; i++) begin
         send_tick(random_request(50));
      end

      // divider sweep; the write frame above carries over into the first setting
      write_divider(16'd1);
      run_random(300, 70, 1'b1);
      write_divider(16'd0);
      run_random(250, 70, 1'b0);
      write_divider(16'd2);
      run_random(300, 80, 1'b0);
      write_divider(16'hFFFF);
      run_random(20, 90, 1'b0);
      // tick count already past the new divider: current half ends at once
      write_divider(16'd1);
      run_random(80, 70, 1'b0);

      drain();
      if (line_check.errors == 0 && line_check.pending() == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
